>>> sv/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types, codes and defaults for the sorted table block.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DELETED  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] entry_count;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic       load;
    logic       rd;
    logic       shift;
    logic       place;
    logic       del_step;
    logic       occ_inc;
    logic       occ_dec;
    logic       out_load;
    logic [2:0] code;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_del;
    logic occ_zero;
    logic full;
    logic idx_zero;
    logic idx_last;
    logic cmp_ge;
    logic cmp_eq;
    logic found;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/sti_datapath.sv
// ----------------------------------------------------------------------------
// sti_datapath
// Entry RAM, scan index, entry count, compare logic and result register.
// ----------------------------------------------------------------------------
module sti_datapath #(
  parameter int unsigned CAPACITY = sti_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sti_pkg::in_word_t  in_word_i,
  input  sti_pkg::ctl_cmd_t  cmd_i,
  output sti_pkg::dp_stat_t  stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output sti_pkg::out_word_t out_word_o
);
  import sti_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [31:0]   ram_q [CAPACITY];
  logic [31:0]   rdata_q;
  logic [31:0]   val_q;
  logic          del_q;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] occ_q, occ_d;
  logic          found_q, found_d;
  logic          out_valid_q;
  out_word_t     out_word_q;

  logic [CW-1:0] idx_m1;
  logic [CW-1:0] occ_m1;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wdata;
  logic          we;

  assign idx_m1  = idx_q - 1'b1;
  assign occ_m1  = occ_q - 1'b1;
  assign raddr   = del_q ? idx_q[AW-1:0] : idx_m1[AW-1:0];
  assign waddr   = del_q ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign wdata   = cmd_i.place ? val_q : rdata_q;
  assign we      = cmd_i.shift | cmd_i.place | (cmd_i.del_step & found_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      ram_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= ram_q[raddr];
    end
    if (cmd_i.load) begin
      val_q <= in_word_i.value;
      del_q <= in_word_i.cmd;
    end
    if (cmd_i.out_load) begin
      out_word_q.status      <= cmd_i.code;
      out_word_q.entry_count <= 5'(occ_q);
    end
  end

  always_comb begin
    idx_d   = idx_q;
    found_d = found_q;
    occ_d   = occ_q;
    if (cmd_i.load) begin
      idx_d   = (in_word_i.cmd == CMD_INSERT) ? occ_q : '0;
      found_d = 1'b0;
    end else if (cmd_i.shift) begin
      idx_d = idx_m1;
    end else if (cmd_i.del_step) begin
      idx_d = idx_q + 1'b1;
      if (rdata_q == val_q) begin
        found_d = 1'b1;
      end
    end
    if (cmd_i.occ_inc) begin
      occ_d = occ_q + 1'b1;
    end else if (cmd_i.occ_dec) begin
      occ_d = occ_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      occ_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      occ_q   <= occ_d;
      found_q <= found_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.is_del   = del_q;
    stat_o.occ_zero = (occ_q == '0);
    stat_o.full     = (occ_q == CW'(CAPACITY));
    stat_o.idx_zero = (idx_q == '0);
    stat_o.idx_last = (idx_q == occ_m1);
    stat_o.cmp_ge   = ($signed(rdata_q) >= $signed(val_q));
    stat_o.cmp_eq   = (rdata_q == val_q);
    stat_o.found    = found_q;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> sv/sti_ctrl.sv
// ----------------------------------------------------------------------------
// sti_ctrl
// Sequencer for insert and delete scans over the entry RAM.
// ----------------------------------------------------------------------------
module sti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sti_pkg::dp_stat_t stat_i,
  output sti_pkg::ctl_cmd_t cmd_o
);
  import sti_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_INSERTED;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    code_d     = code_q;
    cmd_o      = '0;
    cmd_o.code = code_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat_i.is_del) begin
          if (stat_i.full) begin
            code_d  = ST_FULL;
            state_d = S_DONE;
          end else begin
            state_d = S_INS_RD;
          end
        end else if (stat_i.occ_zero) begin
          code_d  = ST_EMPTY;
          state_d = S_DONE;
        end else begin
          state_d = S_DEL_RD;
        end
      end
      S_INS_RD: begin
        if (stat_i.idx_zero) begin
          cmd_o.place   = 1'b1;
          cmd_o.occ_inc = 1'b1;
          code_d        = ST_INSERTED;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat_i.cmp_ge) begin
          cmd_o.shift = 1'b1;
          state_d     = S_INS_RD;
        end else begin
          cmd_o.place   = 1'b1;
          cmd_o.occ_inc = 1'b1;
          code_d        = ST_INSERTED;
          state_d       = S_DONE;
        end
      end
      S_DEL_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        cmd_o.del_step = 1'b1;
        if (stat_i.idx_last) begin
          if (stat_i.found || stat_i.cmp_eq) begin
            cmd_o.occ_dec = 1'b1;
            code_d        = ST_DELETED;
          end else begin
            code_d = ST_NOTFOUND;
          end
          state_d = S_DONE;
        end else begin
          state_d = S_DEL_RD;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/sorted_table_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_delete
// Ordered table of signed keys with insert and delete, one result per word.
// ----------------------------------------------------------------------------
// One word is taken at a time. The entries live in a single-port RAM and each
// scan step is a registered read, then a compare and write back. An insert
// walks over the held entries not less than the new key, since those shift up
// one place from the top down. A delete always walks the whole table, shifting
// the tail down behind the first match. Full and empty cases skip the scan. A
// finished result waits in the output register; the next word is taken while
// it waits, and its own result holds until the register frees.
module sorted_table_insert_delete #(
  parameter int unsigned CAPACITY = sti_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sti_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sti_pkg::out_word_t out_word_o
);
  import sti_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  sti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  sti_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

>>> sv/sti_checker.sv
// ----------------------------------------------------------------------------
// sti_checker
// Port-level checks for the sorted table, bound to the top level.
// ----------------------------------------------------------------------------
module sti_checker #(
  parameter int unsigned CAPACITY = sti_pkg::CAPACITY_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input sti_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sti_pkg::out_word_t out_word_o
);
  import sti_pkg::*;

  localparam logic [4:0] CAP5 = 5'(CAPACITY);

  logic in_seen;
  assign in_seen = in_valid_i && (in_word_i.cmd == CMD_INSERT || in_word_i.cmd == CMD_DELETE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_seen && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in flight");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_EMPTY |-> out_word_o.entry_count == 5'd0)
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_FULL |-> out_word_o.entry_count == CAP5)
    else $error("full status with count below capacity");

endmodule

bind sorted_table_insert_delete sti_checker #(
  .CAPACITY (CAPACITY)
) u_sti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

>>> tb/table_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_scoreboard_pkg
// Expected-result tracking for the sorted table block: keeps its own ordered
// copy of the table, works out status and count for each accepted word, and
// compares every returned word against the oldest expectation.
// ----------------------------------------------------------------------------
package table_scoreboard_pkg;

  import sti_pkg::*;

  class table_scoreboard;

    localparam int unsigned DEPTH = CAPACITY_DEF;

    logic signed [31:0] keys [DEPTH];
    int unsigned        held;
    out_word_t          expected_results [$];
    int unsigned        failures;
    int unsigned        checked;
    int unsigned        status_seen [5];

    function new();
      held     = 0;
      failures = 0;
      checked  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function int unsigned occupancy();
      return held;
    endfunction

    // apply one accepted command to the table copy and queue its result
    function void note_word(in_word_t w);
      out_word_t   r;
      int unsigned pos;
      pos = 0;
      if (w.cmd == CMD_INSERT) begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          while (pos < held && $signed(keys[pos]) < $signed(w.value)) pos++;
          for (int unsigned i = held; i > pos; i--) keys[i] = keys[i - 1];
          keys[pos] = w.value;
          held++;
          r.status = ST_INSERTED;
        end
      end else begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          while (pos < held && keys[pos] != w.value) pos++;
          if (pos >= held) begin
            r.status = ST_NOTFOUND;
          end else begin
            for (int unsigned i = pos; i + 1 < held; i++) keys[i] = keys[i + 1];
            held--;
            r.status = ST_DELETED;
          end
        end
      end
      r.entry_count = 5'(held);
      expected_results.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: status %0d count %0d",
               got.status, got.entry_count);
        failures++;
        return;
      end
      exp_w = expected_results.pop_front();
      checked++;
      if (exp_w.status <= ST_FULL) status_seen[exp_w.status]++;
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, actual %0d", exp_w.status, got.status);
        failures++;
      end
      if (got.entry_count !== exp_w.entry_count) begin
        $error("entry_count: expected %0d, actual %0d",
               exp_w.entry_count, got.entry_count);
        failures++;
      end
    endfunction

  endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sorted_table_insert_delete. A directed run covers the key
// extremes, duplicates, not-found, delete on empty and insert on full; then
// random fill, drain and mixed phases run with random gaps on both sides, a
// long output hold-off and pauses that let the block drain.
// ----------------------------------------------------------------------------
module tb_top;

  import sti_pkg::*;
  import table_scoreboard_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned RAND_BLOCKS  = 12;
  localparam int unsigned BLOCK_WORDS  = 100;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned TAIL_CYCLES  = 60;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  table_scoreboard table_sb;

  logic               calm;
  logic               rx_hold_req;
  int unsigned        rx_hold_left;
  int unsigned        cycles;
  logic signed [31:0] key_pool [8];

  sorted_table_insert_delete u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_ready_i = 1'b0;
    calm        = 1'b0;
    rx_hold_req = 1'b0;
    rx_hold_left = 0;
    cycles      = 0;
  end

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, table_sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, a long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) table_sb.check_word(out_word_o);
  end

  task automatic send_word(input logic cmd, input logic signed [31:0] value);
    in_word_t w;
    w.cmd   = cmd;
    w.value = value;
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    table_sb.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (table_sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return key_pool[$urandom_range(0, 7)];
      6:       return $urandom();
      7:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 20)) - 10;
    endcase
  endfunction

  task automatic refresh_pool();
    foreach (key_pool[i]) begin
      case ($urandom_range(0, 2))
        0:       key_pool[i] = $urandom();
        1:       key_pool[i] = $signed($urandom_range(0, 40)) - 20;
        default: key_pool[i] = -$signed($urandom_range(0, 1000));
      endcase
    end
  endtask

  initial begin
    int unsigned ins_pct;
    table_sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed
    send_word(CMD_DELETE, 32'sd7);
    send_word(CMD_INSERT, 32'sh7fffffff);
    send_word(CMD_INSERT, 32'sh80000000);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_INSERT, -32'sd1);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_DELETE, 32'sd12345);
    for (int i = 0; i < 11; i++) begin
      send_word(CMD_INSERT, (i % 2) ? -(32'sd1 <<< (i * 3)) : (32'sd1 <<< (i * 3)));
    end
    send_word(CMD_INSERT, 32'sd99);
    send_word(CMD_DELETE, 32'sd0);
    send_word(CMD_DELETE, 32'sh80000000);
    send_word(CMD_DELETE, 32'sh7fffffff);
    wait_drained();

    // random: fill, drain and mixed phases
    for (int b = 0; b < RAND_BLOCKS; b++) begin
      refresh_pool();
      calm = (b == 5);
      case (b % 3)
        0:       ins_pct = 80;
        1:       ins_pct = 25;
        default: ins_pct = 50;
      endcase
      if (b == 2) begin
        @(posedge clk_i);
        rx_hold_req = 1'b1;
        @(negedge clk_i);
      end
      for (int n = 0; n < BLOCK_WORDS; n++) begin
        send_word(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE,
                  pick_key());
      end
      if (b == 3 || $urandom_range(0, 2) == 0) wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d results checked: %0d inserted, %0d deleted, %0d not found",
             table_sb.checked, table_sb.status_seen[ST_INSERTED],
             table_sb.status_seen[ST_DELETED], table_sb.status_seen[ST_NOTFOUND]);
    $display("%0d deletes on an empty table, %0d inserts on a full table",
             table_sb.status_seen[ST_EMPTY], table_sb.status_seen[ST_FULL]);
    if (table_sb.failures == 0 && table_sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
